/* rtl/core/tcw_pkg.sv */
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

	localparam int CHAR_W    = 8;
	localparam int COLOR_W   = 4;
	localparam int CELL_W    = 16;
	localparam int IDX_W     = 11;
	localparam int CFG_IDX_W = 8;
	localparam int OUT_ROW_W = 5;
	localparam int OUT_COL_W = 7;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;

	localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 8'd1;

	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	typedef enum logic [1:0] {
		WR_ZERO  = 2'd0,
		WR_BLANK = 2'd1,
		WR_CHAR  = 2'd2
	} wr_sel_t;

	typedef enum logic {
		RD_SHIFT = 1'b0,
		RD_INDEX = 1'b1
	} rd_sel_t;

	typedef struct packed {
		logic    latch;
		logic    ptr_clr;
		logic    ptr_step;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    cur_newline;
		logic    cur_advance;
		logic    res_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       is_newline;
		logic       col_full;
		logic       row_last;
		logic       idx_ok;
		logic       ptr_last;
		logic       copy_last;
		logic       out_free;
	} status_t;

endpackage

`default_nettype wire

/* rtl/core/tcw_dp.sv */
// Datapath: cell store, cursor, sweep pointer, colour registers and result register.
`default_nettype none

module tcw_dp #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire tcw_pkg::cmd_t                cmd,
	output tcw_pkg::status_t                  status,
	input  wire  [1:0]                        in_req,
	input  wire  [tcw_pkg::CHAR_W-1:0]        in_char,
	input  wire  [tcw_pkg::IDX_W-1:0]         in_idx,
	input  wire                               cfg_we,
	input  wire  [tcw_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire  [tcw_pkg::COLOR_W-1:0]       cfg_val,
	input  wire                               res_ready,
	output logic                              res_valid,
	output logic [tcw_pkg::CHAR_W-1:0]        res_char,
	output logic [tcw_pkg::CHAR_W-1:0]        res_color,
	output logic [tcw_pkg::OUT_ROW_W-1:0]     res_row,
	output logic [tcw_pkg::OUT_COL_W-1:0]     res_col
);

	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int COL_W      = $clog2(COLUMNS + 1);
	localparam int CMP_W      = (ADDR_W + 1 > tcw_pkg::IDX_W) ? ADDR_W + 1 : tcw_pkg::IDX_W;

	localparam logic [ADDR_W-1:0] PTR_LAST  = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELL_COUNT - COLUMNS - 1);
	localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

	logic [tcw_pkg::CELL_W-1:0] mem [CELL_COUNT];

	logic [1:0]                   req_q;
	logic [tcw_pkg::CHAR_W-1:0]   char_q;
	logic [tcw_pkg::IDX_W-1:0]    idx_q;
	logic [tcw_pkg::COLOR_W-1:0]  fg_q;
	logic [tcw_pkg::COLOR_W-1:0]  bg_q;
	logic [ROW_W-1:0]             row_q;
	logic [COL_W-1:0]             col_q;
	logic [ADDR_W-1:0]            ptr_q;
	logic [ADDR_W-1:0]            ptr_s1;
	logic                         copy_v_s1;
	logic [tcw_pkg::CELL_W-1:0]   rd_q;

	logic [tcw_pkg::CHAR_W-1:0]   attr;
	logic [ADDR_W-1:0]            cur_addr;
	logic [ADDR_W-1:0]            rd_addr;
	logic                         wr_do;
	logic [ADDR_W-1:0]            wr_addr;
	logic [tcw_pkg::CELL_W-1:0]   wr_data;
	logic                         row_last;
	logic                         idx_ok;

	assign attr     = {bg_q, fg_q};
	assign cur_addr = ADDR_W'(row_q) * ROW_STEP + ADDR_W'(col_q);
	assign row_last = (row_q == ROW_W'(ROWS - 1));
	assign idx_ok   = (CMP_W'(idx_q) < CMP_W'(CELL_COUNT));

	assign status.req        = req_q;
	assign status.is_newline = (char_q == tcw_pkg::NEWLINE_CODE);
	assign status.col_full   = (col_q == COL_W'(COLUMNS));
	assign status.row_last   = row_last;
	assign status.idx_ok     = idx_ok;
	assign status.ptr_last   = (ptr_q == PTR_LAST);
	assign status.copy_last  = (ptr_q == COPY_LAST);
	assign status.out_free   = !res_valid || res_ready;

	// hold the request for the length of its work
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q  <= in_req;
			char_q <= in_char;
			idx_q  <= in_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= tcw_pkg::COLOR_W'(15);
			bg_q <= '0;
		end else if (cfg_we) begin
			if (cfg_idx == tcw_pkg::CFG_FOREGROUND) begin
				fg_q <= cfg_val;
			end else if (cfg_idx == tcw_pkg::CFG_BACKGROUND) begin
				bg_q <= cfg_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.cur_newline) begin
			col_q <= '0;
			if (!row_last) begin
				row_q <= row_q + ROW_W'(1);
			end
		end else if (cmd.cur_advance) begin
			col_q <= col_q + COL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			copy_v_s1 <= 1'b0;
		end else begin
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_step) begin
				ptr_q <= ptr_q + ADDR_W'(1);
			end
			copy_v_s1 <= cmd.rd_en && (cmd.rd_sel == tcw_pkg::RD_SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		ptr_s1 <= ptr_q;
	end

	assign rd_addr = (cmd.rd_sel == tcw_pkg::RD_SHIFT) ? (ptr_q + ROW_STEP) : ADDR_W'(idx_q);

	// a pending scroll copy owns the write port
	always_comb begin
		wr_do   = copy_v_s1 || cmd.wr_en;
		wr_addr = ptr_q;
		wr_data = '0;
		if (copy_v_s1) begin
			wr_addr = ptr_s1;
			wr_data = rd_q;
		end else begin
			unique case (cmd.wr_sel)
				tcw_pkg::WR_ZERO: begin
					wr_data = '0;
				end
				tcw_pkg::WR_BLANK: begin
					wr_data = {attr, tcw_pkg::BLANK_CODE};
				end
				tcw_pkg::WR_CHAR: begin
					wr_addr = cur_addr;
					wr_data = {attr, char_q};
				end
				default: begin
					wr_data = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_do) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.res_load) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			if ((req_q == tcw_pkg::REQ_READ) && idx_ok) begin
				res_char  <= rd_q[tcw_pkg::CHAR_W-1:0];
				res_color <= rd_q[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
			end else begin
				res_char  <= '0;
				res_color <= '0;
			end
			res_row <= tcw_pkg::OUT_ROW_W'(row_q);
			res_col <= tcw_pkg::OUT_COL_W'(col_q);
		end
	end

endmodule

`default_nettype wire

/* rtl/core/tcw_ctrl.sv */
// Controller: sequences request handling, scroll, fills and the clearing pass.
`default_nettype none

module tcw_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire tcw_pkg::status_t   status,
	output tcw_pkg::cmd_t           cmd
);

	typedef enum logic [7:0] {
		ST_INIT     = 8'b0000_0001,
		ST_IDLE     = 8'b0000_0010,
		ST_DISPATCH = 8'b0000_0100,
		ST_SCROLL   = 8'b0000_1000,
		ST_TAIL     = 8'b0001_0000,
		ST_BLANK    = 8'b0010_0000,
		ST_PUT      = 8'b0100_0000,
		ST_RESULT   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   put_pending;

	assign in_ready    = (state_q == ST_IDLE);
	assign put_pending = (status.req == tcw_pkg::REQ_PUT) && !status.is_newline;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_sel   = tcw_pkg::WR_ZERO;
				cmd.ptr_step = 1'b1;
				if (status.ptr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				priority if (status.req == tcw_pkg::REQ_PUT) begin
					if (status.is_newline || status.col_full) begin
						cmd.cur_newline = 1'b1;
						if (status.row_last) begin
							cmd.ptr_clr = 1'b1;
							state_d     = ST_SCROLL;
						end else if (status.is_newline) begin
							state_d = ST_RESULT;
						end else begin
							state_d = ST_PUT;
						end
					end else begin
						cmd.wr_en       = 1'b1;
						cmd.wr_sel      = tcw_pkg::WR_CHAR;
						cmd.cur_advance = 1'b1;
						state_d         = ST_RESULT;
					end
				end else if (status.req == tcw_pkg::REQ_CLEAR) begin
					cmd.ptr_clr = 1'b1;
					state_d     = ST_BLANK;
				end else if (status.req == tcw_pkg::REQ_READ) begin
					cmd.rd_en  = status.idx_ok;
					cmd.rd_sel = tcw_pkg::RD_INDEX;
					state_d    = ST_RESULT;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_SCROLL: begin
				// read one row ahead; the datapath writes the copy in the following cycle
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = tcw_pkg::RD_SHIFT;
				cmd.ptr_step = 1'b1;
				if (status.copy_last) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				state_d = ST_BLANK;
			end
			ST_BLANK: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_sel   = tcw_pkg::WR_BLANK;
				cmd.ptr_step = 1'b1;
				if (status.ptr_last) begin
					state_d = put_pending ? ST_PUT : ST_RESULT;
				end
			end
			ST_PUT: begin
				cmd.wr_en       = 1'b1;
				cmd.wr_sel      = tcw_pkg::WR_CHAR;
				cmd.cur_advance = 1'b1;
				state_d         = ST_RESULT;
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/text_console_writer.sv */
// A scroll or a clear sweeps the whole cell store; a wrap of a full row adds a write step.
// One request at a time, set by the single write port of the cell store during sweeps.
// After reset the store is zeroed with s_tready low; config is taken.
`default_nettype none

module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,    // char_code[7:0], cell_index[18:8], zero pad
	input  wire  [1:0]  s_tuser,    // req_type[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,    // cell_char[7:0], cell_color[15:8], cursor_row[20:16],
	                                // cursor_col[27:21], zero pad
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [7:0]  cfg_index,
	input  wire  [3:0]  cfg_data
);

	tcw_pkg::cmd_t    cmd;
	tcw_pkg::status_t status;

	logic [tcw_pkg::CHAR_W-1:0]    res_char;
	logic [tcw_pkg::CHAR_W-1:0]    res_color;
	logic [tcw_pkg::OUT_ROW_W-1:0] res_row;
	logic [tcw_pkg::OUT_COL_W-1:0] res_col;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {4'b0000, res_col, res_row, res_color, res_char};

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tcw_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_req    (s_tuser),
		.in_char   (s_tdata[7:0]),
		.in_idx    (s_tdata[18:8]),
		.cfg_we    (cfg_valid),
		.cfg_idx   (cfg_index),
		.cfg_val   (cfg_data),
		.res_ready (m_tready),
		.res_valid (m_tvalid),
		.res_char  (res_char),
		.res_color (res_color),
		.res_row   (res_row),
		.res_col   (res_col)
	);

endmodule

`default_nettype wire
